@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Defaults for the queue geometry, operation and status codes, and the
// control bundle broadcast from the queue control to every slot cell.
// ----------------------------------------------------------------------------
package spq_pkg;

   // Default geometry
   localparam int DEF_CAPACITY  = 16;
   localparam int DEF_PRIO_BITS = 8;
   localparam int DEF_TAG_BITS  = 16;

   // Fixed width of the status field
   localparam int STATUS_BITS = 2;

   // Operation codes
   typedef enum logic {
      FUNC_ENQ = 1'b0,
      FUNC_DEQ = 1'b1
   } func_type;

   // Result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   // Per-cycle command to the slot chain
   typedef struct packed {
      logic enq_go;   // insert the new entry at its sorted position
      logic deq_go;   // drop the head, shift every slot toward the head
   } cell_cmd_type;

endpackage

@@ design/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry. On an insert it keeps, takes the new entry, or takes the
// left neighbor's entry; on a removal it takes the right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
#(
   parameter int PRIO_BITS = DEF_PRIO_BITS,
   parameter int TAG_BITS  = DEF_TAG_BITS
) (
   input  logic                 clock,
   input  cell_cmd_type         cmd,
   input  logic                 slot_valid,
   input  logic [TAG_BITS-1:0]  new_tag,
   input  logic [PRIO_BITS-1:0] new_prio,
   input  logic                 left_ins,
   input  logic [TAG_BITS-1:0]  left_tag,
   input  logic [PRIO_BITS-1:0] left_prio,
   input  logic [TAG_BITS-1:0]  right_tag,
   input  logic [PRIO_BITS-1:0] right_prio,
   output logic                 ins,
   output logic [TAG_BITS-1:0]  slot_tag,
   output logic [PRIO_BITS-1:0] slot_prio
);

   logic [TAG_BITS-1:0]  tag_ff;
   logic [TAG_BITS-1:0]  tag_in;
   logic [PRIO_BITS-1:0] prio_ff;
   logic [PRIO_BITS-1:0] prio_in;

   // New entry belongs here or further left: empty slot or strictly larger priority
   assign ins = !slot_valid || (prio_ff > new_prio);

   // Select the next slot contents
   always_comb begin
      tag_in  = tag_ff;
      prio_in = prio_ff;
      priority if (cmd.deq_go) begin
         tag_in  = right_tag;
         prio_in = right_prio;
      end else if (cmd.enq_go && left_ins) begin
         tag_in  = left_tag;
         prio_in = left_prio;
      end else if (cmd.enq_go && ins) begin
         tag_in  = new_tag;
         prio_in = new_prio;
      end else begin
         // Hold the current entry
         tag_in  = tag_ff;
         prio_in = prio_ff;
      end
   end

   // Payload register, no reset needed
   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      prio_ff <= prio_in;
   end

   assign slot_tag  = tag_ff;
   assign slot_prio = prio_ff;

endmodule

@@ design/spq_out_buf.sv @@
// ----------------------------------------------------------------------------
// spq_out_buf: result register with skid stage
// Holds a finished result while the consumer stalls and parks one more in
// the skid stage, so the queue keeps taking items until both are full.
// ----------------------------------------------------------------------------
module spq_out_buf
   import spq_pkg::*;
#(
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [DATA_BITS-1:0] in_data,
   output logic                 in_full,
   output logic                 out_valid,
   output logic [DATA_BITS-1:0] out_data,
   input  logic                 out_stall
);

   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic [DATA_BITS-1:0] out_data_ff;
   logic [DATA_BITS-1:0] out_data_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   logic [DATA_BITS-1:0] skid_data_ff;
   logic [DATA_BITS-1:0] skid_data_in;
   logic                 out_free;

   // Output stage can load when empty or when its transfer completes now
   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         // Drain the skid stage first, else take the new result
         out_valid_in  = skid_valid_ff || in_valid;
         out_data_in   = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (in_valid) begin
         // Park the new result behind the stalled one
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_full   = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ design/stable_priority_queue.sv @@
// Sorted-list priority queue built as a chain of slot cells. Every item is
// either an enqueue (tag plus priority) or a dequeue of the head, and each
// yields exactly one result carrying a status, the dequeued entry and the
// fill level after the operation. Lower priority values leave first; equal
// priorities leave in arrival order. The queue takes one item per clock while
// req_stall is low; its result is registered, or parked in the skid stage
// while the consumer stalls. Every slot compares its own priority with the
// new one in parallel, so the chain length does not change the rate. A result
// register plus one skid stage absorb consumer stalls; req_stall rises only
// when both are occupied. Enqueue into a full queue reports overflow and
// leaves the queue unchanged; dequeue from an empty queue reports underflow.
// ----------------------------------------------------------------------------
// stable_priority_queue: top level
// Fill counter, chain control, slot chain and result buffering.
// ----------------------------------------------------------------------------
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY  = DEF_CAPACITY,
   parameter int PRIO_BITS = DEF_PRIO_BITS,
   parameter int TAG_BITS  = DEF_TAG_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [TAG_BITS-1:0]               req_job_tag,
   input  logic [PRIO_BITS-1:0]              req_job_priority,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [STATUS_BITS-1:0]            rsp_status,
   output logic [TAG_BITS-1:0]               rsp_out_tag,
   output logic [PRIO_BITS-1:0]              rsp_out_priority,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_fill_level
);

   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int DATA_BITS = STATUS_BITS + TAG_BITS + PRIO_BITS + CNT_BITS;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(CAPACITY);

   logic                 req_xfer;
   logic                 is_deq;
   logic                 q_full;
   logic                 q_empty;
   cell_cmd_type         cmd;
   logic [CNT_BITS-1:0]  count_ff;
   logic [CNT_BITS-1:0]  count_in;
   status_type           res_status;
   logic [TAG_BITS-1:0]  res_tag;
   logic [PRIO_BITS-1:0] res_prio;
   logic [DATA_BITS-1:0] res_data;
   logic [DATA_BITS-1:0] rsp_data;
   logic                 buf_full;

   logic [CAPACITY-1:0]  ins_vec;
   logic [TAG_BITS-1:0]  tag_vec  [CAPACITY];
   logic [PRIO_BITS-1:0] prio_vec [CAPACITY];

   // Input transfer and operation decode
   assign req_stall = buf_full;
   assign req_xfer  = req_valid && !req_stall;
   assign is_deq    = (req_func == FUNC_DEQ);
   assign q_full    = (count_ff == FULL_COUNT);
   assign q_empty   = (count_ff == '0);

   // Chain command, fill count and result fields
   always_comb begin
      cmd.enq_go = req_xfer && !is_deq && !q_full;
      cmd.deq_go = req_xfer && is_deq && !q_empty;
      count_in   = count_ff;
      res_status = ST_OK;
      res_tag    = '0;
      res_prio   = '0;
      if (cmd.enq_go) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.deq_go) begin
         count_in = count_ff - 1'b1;
         res_tag  = tag_vec[0];
         res_prio = prio_vec[0];
      end
      if (!is_deq && q_full) begin
         res_status = ST_OVERFLOW;
      end
      if (is_deq && q_empty) begin
         res_status = ST_UNDERFLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Slot chain, head at cell 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                 left_ins;
      logic [TAG_BITS-1:0]  left_tag;
      logic [PRIO_BITS-1:0] left_prio;
      logic [TAG_BITS-1:0]  right_tag;
      logic [PRIO_BITS-1:0] right_prio;

      if (i == 0) begin : g_head
         assign left_ins  = 1'b0;
         assign left_tag  = '0;
         assign left_prio = '0;
      end else begin : g_mid
         assign left_ins  = ins_vec[i-1];
         assign left_tag  = tag_vec[i-1];
         assign left_prio = prio_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_tag  = '0;
         assign right_prio = '0;
      end else begin : g_body
         assign right_tag  = tag_vec[i+1];
         assign right_prio = prio_vec[i+1];
      end

      spq_cell #(
         .PRIO_BITS (PRIO_BITS),
         .TAG_BITS  (TAG_BITS)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .slot_valid (count_ff > CNT_BITS'(i)),
         .new_tag    (req_job_tag),
         .new_prio   (req_job_priority),
         .left_ins   (left_ins),
         .left_tag   (left_tag),
         .left_prio  (left_prio),
         .right_tag  (right_tag),
         .right_prio (right_prio),
         .ins        (ins_vec[i]),
         .slot_tag   (tag_vec[i]),
         .slot_prio  (prio_vec[i])
      );
   end

   // Result buffering
   assign res_data = {res_status, res_tag, res_prio, count_in};

   spq_out_buf #(
      .DATA_BITS (DATA_BITS)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_xfer),
      .in_data   (res_data),
      .in_full   (buf_full),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   assign {rsp_status, rsp_out_tag, rsp_out_priority, rsp_fill_level} = rsp_data;

endmodule

@@ tb/tb_stable_priority_queue.sv @@
// ----------------------------------------------------------------------------
// tb_stable_priority_queue: self-checking testbench for the priority queue
// Drives enqueue and dequeue transfers from a backlog of jobs, predicts each
// result with a sorted shadow list, and checks every result transfer field by
// field. Runs through phases with and without sender idling and receiver
// stalls, plus draining pauses.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;
   import spq_pkg::*;

   localparam int CAP         = DEF_CAPACITY;
   localparam int TAG_W       = DEF_TAG_BITS;
   localparam int PRIO_W      = DEF_PRIO_BITS;
   localparam int FILL_W      = $clog2(DEF_CAPACITY + 1);
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 8;
   localparam int SEGMENTS    = 13;
   localparam int SEG_ITEMS   = 50;

   typedef struct {
      func_type          func;
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      int                idle_pct;
      int                stall_pct;
      bit                drain_first;
   } job_item_type;

   typedef struct {
      status_type        status;
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      logic [FILL_W-1:0] fill;
   } job_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_func;
   logic [TAG_W-1:0]     req_job_tag;
   logic [PRIO_W-1:0]    req_job_priority;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [TAG_W-1:0]     rsp_out_tag;
   logic [PRIO_W-1:0]    rsp_out_priority;
   logic [FILL_W-1:0]    rsp_fill_level;

   job_item_type   job_backlog[$];
   job_result_type due_results[$];
   job_item_type   item_on_bus;
   int             stall_pct;
   int             error_count;
   int             cycle_count;

   // sorted shadow of the slot chain, head at index 0
   logic [TAG_W-1:0]  shadow_tag  [CAP];
   logic [PRIO_W-1:0] shadow_prio [CAP];
   int                shadow_count;

   stable_priority_queue dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_job_tag      (req_job_tag),
      .req_job_priority (req_job_priority),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_priority (rsp_out_priority),
      .rsp_fill_level   (rsp_fill_level)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Apply one queue operation to the shadow list and return its result
   function automatic job_result_type predict_queue_op(job_item_type job);
      job_result_type res;
      int             pos;
      res.status = ST_OK;
      res.tag    = '0;
      res.prio   = '0;
      if (job.func == FUNC_ENQ) begin
         if (shadow_count >= CAP) begin
            res.status = ST_OVERFLOW;
         end else begin
            // stable insert: go past every entry of lower or equal priority
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] <= job.prio) pos++;
            for (int i = shadow_count; i > pos; i--) begin
               shadow_tag[i]  = shadow_tag[i-1];
               shadow_prio[i] = shadow_prio[i-1];
            end
            shadow_tag[pos]  = job.tag;
            shadow_prio[pos] = job.prio;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = ST_UNDERFLOW;
         end else begin
            res.tag  = shadow_tag[0];
            res.prio = shadow_prio[0];
            for (int i = 1; i < shadow_count; i++) begin
               shadow_tag[i-1]  = shadow_tag[i];
               shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
         end
      end
      res.fill = shadow_count[FILL_W-1:0];
      return res;
   endfunction

   task automatic add_job(input func_type f, input logic [TAG_W-1:0] tag,
                          input logic [PRIO_W-1:0] prio, input int idle,
                          input int stall, input bit drain);
      job_item_type job;
      job.func        = f;
      job.tag         = tag;
      job.prio        = prio;
      job.idle_pct    = idle;
      job.stall_pct   = stall;
      job.drain_first = drain;
      job_backlog.push_back(job);
   endtask

   // Driver: record accepted transfers, then present the next job or idle
   always @(posedge clock) begin : driver
      job_item_type nxt;
      bit           present;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            due_results.push_back(predict_queue_op(item_on_bus));
         end
         if (!req_valid || !req_stall) begin
            present = 1'b0;
            if (job_backlog.size() > 0) begin
               nxt = job_backlog[0];
               present = !(nxt.drain_first && due_results.size() > 0) &&
                         ($urandom_range(99) >= nxt.idle_pct);
            end
            if (present) begin
               item_on_bus = nxt;
               void'(job_backlog.pop_front());
               stall_pct = nxt.stall_pct;
               req_func         <= nxt.func;
               req_job_tag      <= nxt.tag;
               req_job_priority <= nxt.prio;
            end
            req_valid <= present;
         end
      end
   end

   // Monitor: check each result transfer, then pick the next stall
   always @(posedge clock) begin : monitor
      job_result_type exp;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got status=%0d tag=%h",
                        $time, rsp_status, rsp_out_tag);
               $display("   prio=%h fill=%0d", rsp_out_priority, rsp_fill_level);
               error_count++;
            end else begin
               exp = due_results.pop_front();
               if (rsp_status !== exp.status || rsp_out_tag !== exp.tag ||
                   rsp_out_priority !== exp.prio || rsp_fill_level !== exp.fill) begin
                  $display("%0t: mismatch expected status=%0d tag=%h prio=%h fill=%0d",
                           $time, exp.status, exp.tag, exp.prio, exp.fill);
                  $display("   got status=%0d tag=%h prio=%h fill=%0d",
                           rsp_status, rsp_out_tag, rsp_out_priority, rsp_fill_level);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Timeout
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_stable_priority_queue NOT OK");
      $finish;
   end

   initial begin : stimulus
      int         idle;
      int         stall;
      int         enq_pct;
      func_type   f;
      logic [PRIO_W-1:0] prio;
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = FUNC_ENQ;
      req_job_tag      = '0;
      req_job_priority = '0;
      rsp_stall        = 1'b0;
      stall_pct        = 0;
      error_count      = 0;
      cycle_count      = 0;
      shadow_count     = 0;

      // empty dequeue, then fill with extremes and ties
      add_job(FUNC_DEQ, 16'h1234, 8'h12, 0, 0, 1'b0);
      add_job(FUNC_ENQ, 16'hFFFF, 8'hFF, 0, 0, 1'b0);
      add_job(FUNC_ENQ, 16'h0000, 8'h00, 0, 0, 1'b0);
      add_job(FUNC_ENQ, 16'h0001, 8'h05, 0, 0, 1'b0);
      add_job(FUNC_ENQ, 16'h0002, 8'h05, 0, 0, 1'b0);
      add_job(FUNC_ENQ, 16'h0003, 8'h05, 0, 0, 1'b0);
      add_job(FUNC_ENQ, 16'h0004, 8'h00, 0, 0, 1'b0);
      add_job(FUNC_ENQ, 16'h0005, 8'hFF, 0, 0, 1'b0);
      add_job(FUNC_ENQ, 16'hAAAA, 8'h80, 0, 0, 1'b0);
      add_job(FUNC_ENQ, 16'h5555, 8'h7F, 0, 0, 1'b0);
      for (int k = 0; k < 7; k++) begin
         add_job(FUNC_ENQ, TAG_W'(16'h0100 + k), 8'((k % 3) * 2), 0, 0, 1'b0);
      end
      // full queue: overflow, then take a few from the head
      add_job(FUNC_ENQ, 16'hFFFF, 8'h00, 0, 0, 1'b0);
      for (int k = 0; k < 5; k++) begin
         add_job(FUNC_DEQ, 16'hFFFF, 8'hFF, 0, 0, 1'b0);
      end

      // random segments: rotate idling phases and fill bias
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 4)
            0: begin idle = 0;  stall = 0;  end
            1: begin idle = 57; stall = 0;  end
            2: begin idle = 0;  stall = 57; end
            default: begin idle = 18; stall = 18; end
         endcase
         case (seg % 3)
            0: enq_pct = 75;
            1: enq_pct = 30;
            default: enq_pct = 55;
         endcase
         for (int i = 0; i < SEG_ITEMS; i++) begin
            f = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
            // mostly narrow priorities to produce ties, sometimes full range
            prio = ($urandom_range(99) < 75) ? PRIO_W'($urandom_range(7))
                                             : PRIO_W'($urandom_range(255));
            add_job(f, TAG_W'($urandom), prio, idle, stall, i == 0);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // wait for the backlog and every due result, then settle
      do @(posedge clock);
      while (job_backlog.size() != 0 || req_valid || due_results.size() != 0);
      repeat (SETTLE) @(posedge clock);

      if (error_count == 0 && due_results.size() == 0) begin
         $display("tb_stable_priority_queue OK");
      end else begin
         $display("tb_stable_priority_queue NOT OK");
      end
      $finish;
   end

endmodule
